// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- design/mcf_pkg.sv -----
package mcf_pkg;

    localparam logic [3:0] KIND_LOCAL_ADDR = 4'd0;
    localparam logic [3:0] KIND_PROG_ADDR  = 4'd1;
    localparam logic [3:0] KIND_ABORT_PROG = 4'd2;
    localparam logic [3:0] KIND_SPEED      = 4'd3;
    localparam logic [3:0] KIND_ACCEL      = 4'd4;
    localparam logic [3:0] KIND_DECEL      = 4'd5;
    localparam logic [3:0] KIND_DIRECTION  = 4'd6;
    localparam logic [3:0] KIND_STATUS     = 4'd7;
    localparam logic [3:0] KIND_START      = 4'd8;
    localparam logic [3:0] KIND_STOP       = 4'd9;

    localparam logic [7:0] MCF_SYNC_BYTE    = 8'hE6;
    localparam logic [7:0] MCF_PROG_ADDRESS = 8'hFF;
    localparam logic [7:0] CODE_ADDR_SET    = 8'hA0;
    localparam logic [7:0] CODE_ADDR_ABORT  = 8'hA1;
    localparam logic [7:0] CODE_SPEED       = 8'hA3;
    localparam logic [7:0] CODE_ACCEL       = 8'hA5;
    localparam logic [7:0] CODE_DECEL       = 8'hA6;
    localparam logic [7:0] CODE_DIRECTION   = 8'hA7;
    localparam logic [7:0] CODE_STATUS      = 8'h50;
    localparam logic [7:0] CODE_START       = 8'h51;
    localparam logic [7:0] CODE_STOP        = 8'h52;
    localparam logic [7:0] MCF_CRC_FEEDBACK = 8'h18;
    localparam logic [7:0] MCF_DEFAULT_RAMP = 8'h18;
    localparam logic [7:0] MCF_ONE          = 8'h01;

    localparam int MCF_START_FRAMES = 5;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] code;
        logic [7:0] val;
        logic       last;
    } t_frame;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_LAUNCH,
        TS_WAIT
    } t_top_state;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_SYNC,
        SQ_ADDR,
        SQ_CODE,
        SQ_VAL,
        SQ_CRC,
        SQ_HOLD
    } t_seq_state;

endpackage

// ----- design/mcf_crc_unit.sv -----
module mcf_crc_unit (
    input  logic       i_clk,
    input  logic       i_clear,
    input  logic       i_en,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc
);
    import mcf_pkg::*;

    logic [7:0] r_crc;
    logic [7:0] n_crc;

    always_comb begin
        logic [7:0] c;
        logic [7:0] d;
        c = r_crc;
        d = i_data;
        for (int i = 0; i < 8; i++) begin
            if ((c[0] ^ d[0]) == 1'b1) begin
                c = ((c ^ MCF_CRC_FEEDBACK) >> 1) | 8'h80;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        n_crc = c;
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_crc <= 8'h00;
        end else if (i_en) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

// ----- design/mcf_frame_seq.sv -----
module mcf_frame_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mcf_pkg::t_frame i_frame,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_eof,
    output logic            o_eor,
    output logic            o_idle,
    output logic            o_done
);
    import mcf_pkg::*;

    t_seq_state r_state;
    t_seq_state n_state;
    t_frame     r_frame;
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       r_eof;
    logic       n_eof;
    logic       r_eor;
    logic       n_eor;
    logic       can_load;
    logic       crc_clear;
    logic       crc_en;
    logic [7:0] crc;

    mcf_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_clear (crc_clear),
        .i_en    (crc_en),
        .i_data  (n_byte),
        .o_crc   (crc)
    );

    assign can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_eof  <= n_eof;
        r_eor  <= n_eor;
        if (r_state == SQ_IDLE && i_start) begin
            r_frame <= i_frame;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid && !i_ready;
        n_byte    = r_byte;
        n_eof     = r_eof;
        n_eor     = r_eor;
        crc_clear = 1'b0;
        crc_en    = 1'b0;
        o_done    = 1'b0;
        unique case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    crc_clear = 1'b1;
                    n_state   = SQ_SYNC;
                end
            end
            SQ_SYNC: begin
                if (can_load) begin
                    n_byte  = MCF_SYNC_BYTE;
                    n_eof   = 1'b0;
                    n_eor   = 1'b0;
                    n_valid = 1'b1;
                    n_state = SQ_ADDR;
                end
            end
            SQ_ADDR: begin
                if (can_load) begin
                    n_byte  = r_frame.addr;
                    n_valid = 1'b1;
                    crc_en  = 1'b1;
                    n_state = SQ_CODE;
                end
            end
            SQ_CODE: begin
                if (can_load) begin
                    n_byte  = r_frame.code;
                    n_valid = 1'b1;
                    crc_en  = 1'b1;
                    n_state = SQ_VAL;
                end
            end
            SQ_VAL: begin
                if (can_load) begin
                    n_byte  = r_frame.val;
                    n_valid = 1'b1;
                    crc_en  = 1'b1;
                    n_state = SQ_CRC;
                end
            end
            SQ_CRC: begin
                if (can_load) begin
                    n_byte  = crc;
                    n_eof   = 1'b1;
                    n_eor   = r_frame.last;
                    n_valid = 1'b1;
                    n_state = SQ_HOLD;
                end
            end
            SQ_HOLD: begin
                if (i_ready) begin
                    o_done  = 1'b1;
                    n_state = SQ_IDLE;
                end
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eof   = r_eof;
    assign o_eor   = r_eor;
    assign o_idle  = (r_state == SQ_IDLE);

endmodule

// ----- design/motor_command_framer_crc8_core.sv -----
// The first frame byte passes the top-level launch state, the sequencer sync
// state and the output byte register. A new command is accepted only once all
// bytes of the previous one are taken; local address set and unknown kinds
// emit no frames. The byte sequencer and its CRC unit build the frames.
// Reset (i_rst_n low, synchronous) clears the stored address, speed and
// direction, sets both ramps to 24 and clears the running flag.
`include "assert_macros.svh"

module motor_command_framer_crc8_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] value
    input  logic [3:0] s_axis_tuser,  // [3:0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] frame_byte
    output logic       m_axis_tlast,  // end_of_run
    output logic [1:0] m_axis_tuser   // [0] end_of_frame, [1] running
);
    import mcf_pkg::*;

    t_top_state r_state;
    t_top_state n_state;
    logic [3:0] r_kind;
    logic [7:0] r_val;
    logic [2:0] r_frame_idx;
    logic [2:0] n_frame_idx;
    logic [7:0] r_address;
    logic [7:0] r_speed;
    logic [7:0] r_accel;
    logic [7:0] r_decel;
    logic [7:0] r_direction;
    logic       r_run_flag;
    logic       in_fire;
    logic       kind_emits;
    logic       seq_start;
    logic       seq_idle;
    logic       seq_done;
    logic       seq_eof;
    t_frame     frame;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_comb begin
        kind_emits = 1'b0;
        unique case (s_axis_tuser)
            KIND_PROG_ADDR, KIND_ABORT_PROG, KIND_SPEED, KIND_ACCEL,
            KIND_DECEL, KIND_DIRECTION, KIND_STATUS, KIND_START,
            KIND_STOP: kind_emits = 1'b1;
            default:   kind_emits = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TS_IDLE;
            r_frame_idx <= 3'd0;
            r_address   <= 8'h00;
            r_speed     <= 8'h00;
            r_accel     <= MCF_DEFAULT_RAMP;
            r_decel     <= MCF_DEFAULT_RAMP;
            r_direction <= 8'h00;
            r_run_flag  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frame_idx <= n_frame_idx;
            if (in_fire) begin
                unique case (s_axis_tuser)
                    KIND_LOCAL_ADDR, KIND_PROG_ADDR: r_address   <= s_axis_tdata;
                    KIND_SPEED:                      r_speed     <= s_axis_tdata;
                    KIND_ACCEL:                      r_accel     <= s_axis_tdata;
                    KIND_DECEL:                      r_decel     <= s_axis_tdata;
                    KIND_DIRECTION:                  r_direction <= s_axis_tdata;
                    KIND_START:                      r_run_flag  <= 1'b1;
                    KIND_STOP:                       r_run_flag  <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= s_axis_tuser;
            r_val  <= s_axis_tdata;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_frame_idx   = r_frame_idx;
        s_axis_tready = 1'b0;
        seq_start     = 1'b0;
        unique case (r_state)
            TS_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && kind_emits) begin
                    n_frame_idx = 3'd0;
                    n_state     = TS_LAUNCH;
                end
            end
            TS_LAUNCH: begin
                seq_start = 1'b1;
                n_state   = TS_WAIT;
            end
            TS_WAIT: begin
                if (seq_done) begin
                    if (frame.last) begin
                        n_state = TS_IDLE;
                    end else begin
                        n_frame_idx = r_frame_idx + 3'd1;
                        n_state     = TS_LAUNCH;
                    end
                end
            end
            default: begin
                n_state = TS_IDLE;
            end
        endcase
    end

    always_comb begin
        frame.addr = r_address;
        frame.code = CODE_STATUS;
        frame.val  = MCF_ONE;
        frame.last = 1'b1;
        unique case (r_kind)
            KIND_PROG_ADDR: begin
                frame.addr = MCF_PROG_ADDRESS;
                frame.code = CODE_ADDR_SET;
                frame.val  = r_val;
            end
            KIND_ABORT_PROG: begin
                frame.addr = MCF_PROG_ADDRESS;
                frame.code = CODE_ADDR_ABORT;
            end
            KIND_SPEED: begin
                frame.code = CODE_SPEED;
                frame.val  = r_val;
            end
            KIND_ACCEL: begin
                frame.code = CODE_ACCEL;
                frame.val  = r_val;
            end
            KIND_DECEL: begin
                frame.code = CODE_DECEL;
                frame.val  = r_val;
            end
            KIND_DIRECTION: begin
                frame.code = CODE_DIRECTION;
                frame.val  = r_val;
            end
            KIND_STOP: begin
                frame.code = CODE_STOP;
            end
            KIND_START: begin
                frame.last = (r_frame_idx == 3'(MCF_START_FRAMES - 1));
                unique case (r_frame_idx)
                    3'd0: begin
                        frame.code = CODE_ACCEL;
                        frame.val  = r_accel;
                    end
                    3'd1: begin
                        frame.code = CODE_DECEL;
                        frame.val  = r_decel;
                    end
                    3'd2: begin
                        frame.code = CODE_SPEED;
                        frame.val  = r_speed;
                    end
                    3'd3: begin
                        frame.code = CODE_DIRECTION;
                        frame.val  = r_direction;
                    end
                    default: begin
                        frame.code = CODE_START;
                    end
                endcase
            end
            default: ;
        endcase
    end

    mcf_frame_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (seq_start),
        .i_frame (frame),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_byte  (m_axis_tdata),
        .o_eof   (seq_eof),
        .o_eor   (m_axis_tlast),
        .o_idle  (seq_idle),
        .o_done  (seq_done)
    );

    assign m_axis_tuser = {r_run_flag, seq_eof};

    `ASSERT_CLK(a_idle_drained, i_clk, i_rst_n, s_axis_tready |-> !m_axis_tvalid)
    `ASSERT_CLK(a_launch_seq_idle, i_clk, i_rst_n, seq_start |-> seq_idle)
    `ASSERT_CLK(a_run_end_frame, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tlast) |-> seq_eof)
    `ASSERT_CLK(a_start_sets_run, i_clk, i_rst_n, (in_fire && s_axis_tuser == KIND_START) |=> r_run_flag)
    `ASSERT_CLK(a_frame_idx_range, i_clk, i_rst_n, r_frame_idx <= 3'(MCF_START_FRAMES - 1))

endmodule

// ----- bench/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcf_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       eor;
        logic       running;
    } t_wire_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;  // [7:0] value
    logic [3:0] s_axis_tuser = '0;  // [3:0] kind
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;       // [7:0] frame_byte
    logic       m_axis_tlast;       // end_of_run
    logic [1:0] m_axis_tuser;       // [0] end_of_frame, [1] running

    motor_command_framer_crc8_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // model state
    logic [7:0] dev_addr;
    logic [7:0] speed_q;
    logic [7:0] accel_q;
    logic [7:0] decel_q;
    logic [7:0] dir_q;
    logic       run_q;

    t_wire_byte frames_due[$];
    t_wire_byte run_bytes[$];

    int send_idle_pct;
    int recv_idle_pct;
    int cmds_sent;
    int mismatch_count;
    int byte_index;
    int quiet_cycles;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] crc8_maxim_update(input logic [7:0] crc_in,
                                                     input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] d;
        crc = crc_in;
        d   = data_in;
        for (int i = 0; i < 8; i++) begin
            if (crc[0] ^ d[0]) begin
                crc = ((crc ^ MCF_CRC_FEEDBACK) >> 1) | 8'h80;
            end else begin
                crc = crc >> 1;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

    task automatic append_frame(input logic [7:0] addr, input logic [7:0] code,
                                input logic [7:0] val);
        logic [7:0] crc;
        crc = crc8_maxim_update(8'h00, addr);
        crc = crc8_maxim_update(crc, code);
        crc = crc8_maxim_update(crc, val);
        run_bytes.push_back('{MCF_SYNC_BYTE, 1'b0, 1'b0, 1'b0});
        run_bytes.push_back('{addr, 1'b0, 1'b0, 1'b0});
        run_bytes.push_back('{code, 1'b0, 1'b0, 1'b0});
        run_bytes.push_back('{val, 1'b0, 1'b0, 1'b0});
        run_bytes.push_back('{crc, 1'b1, 1'b0, 1'b0});
    endtask

    task automatic predict_frames(input logic [3:0] kind, input logic [7:0] value);
        t_wire_byte b;
        run_bytes.delete();
        case (kind)
            KIND_LOCAL_ADDR: begin
                dev_addr = value;
            end
            KIND_PROG_ADDR: begin
                append_frame(MCF_PROG_ADDRESS, CODE_ADDR_SET, value);
                dev_addr = value;
            end
            KIND_ABORT_PROG: begin
                append_frame(MCF_PROG_ADDRESS, CODE_ADDR_ABORT, MCF_ONE);
            end
            KIND_SPEED: begin
                append_frame(dev_addr, CODE_SPEED, value);
                speed_q = value;
            end
            KIND_ACCEL: begin
                append_frame(dev_addr, CODE_ACCEL, value);
                accel_q = value;
            end
            KIND_DECEL: begin
                append_frame(dev_addr, CODE_DECEL, value);
                decel_q = value;
            end
            KIND_DIRECTION: begin
                append_frame(dev_addr, CODE_DIRECTION, value);
                dir_q = value;
            end
            KIND_STATUS: begin
                append_frame(dev_addr, CODE_STATUS, MCF_ONE);
            end
            KIND_START: begin
                append_frame(dev_addr, CODE_ACCEL, accel_q);
                append_frame(dev_addr, CODE_DECEL, decel_q);
                append_frame(dev_addr, CODE_SPEED, speed_q);
                append_frame(dev_addr, CODE_DIRECTION, dir_q);
                append_frame(dev_addr, CODE_START, MCF_ONE);
                run_q = 1'b1;
            end
            KIND_STOP: begin
                append_frame(dev_addr, CODE_STOP, MCF_ONE);
                run_q = 1'b0;
            end
            default: begin
            end
        endcase
        foreach (run_bytes[i]) begin
            b         = run_bytes[i];
            b.running = run_q;
            b.eor     = (i == run_bytes.size() - 1);
            frames_due.push_back(b);
        end
    endtask

    // tvalid stays high across back-to-back transactions; drop it only while idling
    task automatic send_cmd(input logic [3:0] kind, input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_frames(kind, value);
        if (kind <= KIND_STOP) cmds_sent++;
    endtask

    task automatic wait_drained();
        while (frames_due.size() != 0) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_wire_byte exp_b;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frames_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected byte %0d: data=%02h eof=%b eor=%b run=%b",
                             byte_index, m_axis_tdata, m_axis_tuser[0], m_axis_tlast,
                             m_axis_tuser[1]);
            end else begin
                exp_b = frames_due.pop_front();
                if (m_axis_tdata !== exp_b.data || m_axis_tuser[0] !== exp_b.eof ||
                    m_axis_tlast !== exp_b.eor || m_axis_tuser[1] !== exp_b.running) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("byte %0d exp %02h/%b/%b/%b got %02h/%b/%b/%b",
                                 byte_index, exp_b.data, exp_b.eof, exp_b.eor,
                                 exp_b.running, m_axis_tdata, m_axis_tuser[0],
                                 m_axis_tlast, m_axis_tuser[1]);
                end
            end
            byte_index++;
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic test_reset_defaults();
        send_cmd(KIND_START, 8'h00);
        send_cmd(KIND_STOP, 8'h00);
        send_cmd(KIND_STOP, 8'hFF);
        send_cmd(KIND_STATUS, 8'hFF);
    endtask

    task automatic test_each_command();
        send_cmd(KIND_LOCAL_ADDR, 8'hFF);
        send_cmd(KIND_STATUS, 8'h00);
        send_cmd(KIND_PROG_ADDR, 8'hFF);
        send_cmd(KIND_ABORT_PROG, 8'h00);
        send_cmd(KIND_PROG_ADDR, 8'h00);
        send_cmd(KIND_SPEED, 8'hFF);
        send_cmd(KIND_ACCEL, 8'h00);
        send_cmd(KIND_DECEL, 8'hFF);
        send_cmd(KIND_DIRECTION, 8'hAA);
        send_cmd(KIND_START, 8'hFF);
        send_cmd(KIND_START, 8'h00);
        send_cmd(KIND_STOP, 8'h00);
        send_cmd(KIND_LOCAL_ADDR, 8'h5A);
        send_cmd(KIND_SPEED, 8'h00);
        send_cmd(KIND_DIRECTION, 8'h55);
        send_cmd(KIND_START, 8'h00);
    endtask

    task automatic test_unknown_kinds();
        for (int k = 10; k < 16; k++) begin
            send_cmd(4'(k), (k % 2) ? 8'hFF : 8'h00);
        end
        send_cmd(KIND_STOP, 8'h00);
    endtask

    function automatic logic [7:0] rand_value();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 8'h00;
        if (r < 16) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_noise();
        int r;
        r = $urandom_range(99);
        if (r < 12) send_cmd(4'($urandom_range(15, 10)), rand_value());
        else if (r < 20) send_cmd(KIND_START, rand_value());
        else send_cmd(4'($urandom_range(9)), rand_value());
    endtask

    task automatic send_session();
        int n_params;
        if ($urandom_range(1)) send_cmd($urandom_range(1) ? KIND_LOCAL_ADDR : KIND_PROG_ADDR,
                                        rand_value());
        n_params = $urandom_range(3, 1);
        repeat (n_params) send_cmd(4'($urandom_range(KIND_DIRECTION, KIND_SPEED)), rand_value());
        send_cmd(KIND_START, rand_value());
        if ($urandom_range(2) == 0) send_cmd(KIND_STATUS, rand_value());
        if ($urandom_range(3) != 0) send_cmd(KIND_STOP, rand_value());
    endtask

    task automatic test_random_traffic(input int n_cmds, input int snd_pct, input int rcv_pct);
        int target;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        target = cmds_sent + n_cmds;
        wait_drained();
        while (cmds_sent < target) begin
            if ($urandom_range(99) < 55) send_session();
            else send_noise();
            if ($urandom_range(99) < 3) wait_drained();
        end
    endtask

    initial begin
        dev_addr       = 8'h00;
        speed_q        = 8'h00;
        accel_q        = MCF_DEFAULT_RAMP;
        decel_q        = MCF_DEFAULT_RAMP;
        dir_q          = 8'h00;
        run_q          = 1'b0;
        mismatch_count = 0;
        byte_index     = 0;
        cmds_sent      = 0;
        send_idle_pct  = 19;
        recv_idle_pct  = 64;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_each_command();
        test_unknown_kinds();
        test_random_traffic(120, 19, 64);
        test_random_traffic(120, 64, 19);
        test_random_traffic(110, 0, 0);

        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && frames_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
